FILE: src/tpgm_pkg.sv
// Shared types and constants for the touch and pointer gesture mapper.
package tpgm_pkg;

    typedef enum logic [1:0] {
        MODE_ABS    = 2'd0,
        MODE_REL    = 2'd1,
        MODE_TOUCH  = 2'd2,
        MODE_FROZEN = 2'd3
    } mode_t;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [11:0] RESET_WIDTH  = 12'd640;
    localparam logic [11:0] RESET_HEIGHT = 12'd480;
    localparam logic [11:0] SIZE_MIN     = 12'd256;
    localparam logic [11:0] SIZE_MAX     = 12'd2048;
    localparam logic [11:0] RIGHT_MARGIN = 12'd10;

    localparam logic [10:0] CURSOR_RESET_X = 11'd250;
    localparam logic [10:0] CURSOR_RESET_Y = 11'd165;
    localparam logic [10:0] CURSOR_X_MAX   = 11'd2038;

    localparam logic [15:0] SCALE_OFS = 16'h7fff;
    localparam logic [16:0] SCALE_DIV = 17'h0fffe;
    localparam logic [15:0] TOUCH_MIN = 16'h8000;

    localparam logic [16:0] DRAG_START     = 17'd256;
    localparam logic [16:0] DRAG_START_NEG = 17'h1ff00;
    localparam logic [17:0] DRAG_ROUND     = 18'd63;

    localparam logic [31:0] HOLD_US = 32'd500000;
    localparam logic [31:0] TAP_US  = 32'd100000;

    typedef struct packed {
        logic [1:0]  touch_count;
        logic [15:0] touch_x;
        logic [15:0] touch_y;
        logic [15:0] mouse_dx;
        logic [15:0] mouse_dy;
        logic [2:0]  mouse_buttons;
        logic [31:0] time_us;
    } frame_t;

    typedef struct packed {
        frame_t      frame;
        logic [11:0] abs_x;
        logic [11:0] abs_y;
    } prep_t;

endpackage

FILE: src/touch_pointer_gesture_mapper.sv
// Top level of the touch and pointer gesture mapper.
// Maps one poll frame per request (touch count and position, mouse deltas and buttons, time
// stamp) to the clamped cursor, the frame's motion delta and the held button levels. Modes:
// 0 scales the touch position to the screen, 1 adds the mouse deltas, 2 runs touchpad
// gestures (tap, hold, drag), 3 reports mouse data and leaves the cursor still. The result
// of a request passes the input register, the scaling register and the result register, and a
// new one is accepted every cycle unless out_ready holds the pipeline; the combinational update
// of the gesture and cursor state in the core sets that rate. Screen size is saturated to
// 256..2048. Write the configuration registers only while no request is in flight.
module touch_pointer_gesture_mapper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  touch_count,
    input  logic [15:0] touch_x,
    input  logic [15:0] touch_y,
    input  logic [15:0] mouse_dx,
    input  logic [15:0] mouse_dy,
    input  logic [2:0]  mouse_buttons,
    input  logic [31:0] time_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] cursor_x,
    output logic [10:0] cursor_y,
    output logic [15:0] delta_x,
    output logic [15:0] delta_y,
    output logic [2:0]  button_levels
);

    tpgm_pkg::mode_t  mode_reg;
    logic [11:0]      width_reg;
    logic [11:0]      height_reg;
    logic [11:0]      w_sat, h_sat;
    tpgm_pkg::frame_t frame;
    tpgm_pkg::prep_t  prep;
    logic             prep_valid, prep_ready;

    function automatic logic [11:0] sat_size(input logic [11:0] v);
        if (v < tpgm_pkg::SIZE_MIN)
            return tpgm_pkg::SIZE_MIN;
        else if (v > tpgm_pkg::SIZE_MAX)
            return tpgm_pkg::SIZE_MAX;
        else
            return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= tpgm_pkg::MODE_ABS;
            width_reg  <= tpgm_pkg::RESET_WIDTH;
            height_reg <= tpgm_pkg::RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpgm_pkg::REG_MODE:   mode_reg   <= tpgm_pkg::mode_t'(cfg_data[1:0]);
                tpgm_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                tpgm_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w_sat = sat_size(width_reg);
    assign h_sat = sat_size(height_reg);

    assign frame.touch_count   = touch_count;
    assign frame.touch_x       = touch_x;
    assign frame.touch_y       = touch_y;
    assign frame.mouse_dx      = mouse_dx;
    assign frame.mouse_dy      = mouse_dy;
    assign frame.mouse_buttons = mouse_buttons;
    assign frame.time_us       = time_us;

    tpgm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frame      (frame),
        .w_sat      (w_sat),
        .h_sat      (h_sat),
        .prep_valid (prep_valid),
        .prep_ready (prep_ready),
        .prep       (prep)
    );

    tpgm_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode_reg),
        .w_sat         (w_sat),
        .h_sat         (h_sat),
        .prep_valid    (prep_valid),
        .prep_ready    (prep_ready),
        .prep          (prep),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cursor_x      (cursor_x),
        .cursor_y      (cursor_y),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .button_levels (button_levels)
    );

endmodule

FILE: src/tpgm_front.sv
// Input register and absolute-position scaling stage.
module tpgm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tpgm_pkg::frame_t    frame,
    input  logic [11:0]         w_sat,
    input  logic [11:0]         h_sat,
    output logic                prep_valid,
    input  logic                prep_ready,
    output tpgm_pkg::prep_t     prep
);

    logic             s1_valid_reg;
    tpgm_pkg::frame_t s1_frame_reg;
    logic             s2_valid_reg;
    tpgm_pkg::prep_t  s2_prep_reg;
    logic             s2_load;

    // (t + 0x7fff) * size + size/2 - 1, divided by 0xfffe.
    // Split n = h * 2^16 + l, so n = h * 0xfffe + (2h + l) and 2h + l < 2 * 0xfffe.
    function automatic logic [11:0] scale_abs(input logic [15:0] t, input logic [11:0] size);
        logic [15:0] a;
        logic [26:0] n;
        logic [10:0] hi;
        logic [16:0] r;
        a  = (t == tpgm_pkg::TOUCH_MIN) ? 16'd0 : t + tpgm_pkg::SCALE_OFS;
        n  = 27'(a) * 27'(size) + 27'(size[11:1]) - 27'd1;
        hi = n[26:16];
        r  = {5'd0, hi, 1'b0} + {1'b0, n[15:0]};
        return {1'b0, hi} + ((r >= tpgm_pkg::SCALE_DIV) ? 12'd1 : 12'd0);
    endfunction

    assign s2_load    = !s2_valid_reg || prep_ready;
    assign in_ready   = !s1_valid_reg || s2_load;
    assign prep_valid = s2_valid_reg;
    assign prep       = s2_prep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_frame_reg <= frame;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_prep_reg.frame <= s1_frame_reg;
            s2_prep_reg.abs_x <= scale_abs(s1_frame_reg.touch_x, w_sat);
            s2_prep_reg.abs_y <= scale_abs(s1_frame_reg.touch_y, h_sat);
        end
    end

endmodule

FILE: src/tpgm_core.sv
// Gesture state, cursor update and result register.
module tpgm_core (
    input  logic                clk,
    input  logic                rst_n,
    input  tpgm_pkg::mode_t     mode,
    input  logic [11:0]         w_sat,
    input  logic [11:0]         h_sat,
    input  logic                prep_valid,
    output logic                prep_ready,
    input  tpgm_pkg::prep_t     prep,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [10:0]         cursor_x,
    output logic [10:0]         cursor_y,
    output logic [15:0]         delta_x,
    output logic [15:0]         delta_y,
    output logic [2:0]          button_levels
);

    typedef struct packed {
        logic [1:0]  prev_count;
        logic [1:0]  held_button;
        logic        held_active;
        logic        moving;
        logic        tap_click;
        logic [15:0] anchor_x;
        logic [15:0] anchor_y;
        logic [6:0]  rem_x;
        logic [6:0]  rem_y;
        logic [31:0] press_time;
        logic        press_armed;
        logic [31:0] hold_time;
        logic [2:0]  levels;
    } pad_state_t;

    typedef struct packed {
        logic [11:0] q;
        logic [6:0]  r;
    } div_t;

    pad_state_t  st_reg, st_next;
    logic [10:0] cx_reg, cy_reg;
    logic [10:0] cx_next, cy_next;
    logic        out_valid_reg;
    logic [15:0] dx_out_reg, dy_out_reg;
    logic [15:0] rel_x, rel_y;
    logic [17:0] px, py;
    logic [16:0] dx_raw, dy_raw;
    logic [17:0] dx_acc, dy_acc;
    div_t        dq_x, dq_y;
    logic        rise;
    logic        take;
    logic [11:0] hi_x, hi_y;
    tpgm_pkg::frame_t f;

    function automatic logic [2:0] btn_mask(input logic [1:0] b);
        case (b)
            2'd0:    return 3'b001;
            2'd1:    return 3'b010;
            2'd2:    return 3'b100;
            default: return 3'b000;
        endcase
    endfunction

    function automatic logic far_move(input logic [16:0] d);
        return d[16] ? (d <= tpgm_pkg::DRAG_START_NEG) : (d >= tpgm_pkg::DRAG_START);
    endfunction

    // Truncating divide by 64, remainder keeps the sign of the dividend
    function automatic div_t div64(input logic [17:0] d);
        logic [17:0] adj;
        div_t        res;
        adj   = d + (d[17] ? tpgm_pkg::DRAG_ROUND : 18'd0);
        res.q = adj[17:6];
        res.r = d[6:0] - {adj[6], 6'd0};
        return res;
    endfunction

    function automatic logic [10:0] clamp_pos(input logic [17:0] v, input logic [11:0] hi);
        if (v[17])
            return 11'd0;
        else if (v[16:0] > {5'd0, hi})
            return hi[10:0];
        else
            return v[10:0];
    endfunction

    assign f          = prep.frame;
    assign prep_ready = !out_valid_reg || out_ready;
    assign take       = prep_valid && prep_ready;
    assign hi_x       = w_sat - tpgm_pkg::RIGHT_MARGIN;
    assign hi_y       = h_sat - 12'd1;

    always_comb
    begin
        st_next = st_reg;
        px      = {7'd0, cx_reg};
        py      = {7'd0, cy_reg};
        rel_x   = 16'd0;
        rel_y   = 16'd0;
        rise    = f.touch_count > st_reg.prev_count;
        dx_raw  = 17'd0;
        dy_raw  = 17'd0;
        dx_acc  = 18'd0;
        dy_acc  = 18'd0;
        dq_x    = '0;
        dq_y    = '0;
        case (mode)
            tpgm_pkg::MODE_TOUCH:
            begin
                if (f.touch_count != st_reg.prev_count)
                begin
                    if (rise)
                    begin
                        st_next.press_time  = f.time_us;
                        st_next.press_armed = 1'b1;
                    end
                    // release of fingers after a short press counts as a tap
                    if (!st_next.held_active && !rise && st_next.press_armed &&
                        (!st_next.moving || f.touch_count != 2'd0))
                    begin
                        st_next.held_active = 1'b1;
                        st_next.hold_time   = f.time_us;
                        st_next.tap_click   = 1'b1;
                        st_next.held_button = f.touch_count;
                        st_next.levels      = st_next.levels | btn_mask(f.touch_count);
                        st_next.press_armed = 1'b0;
                    end
                    else if (st_next.held_active && (f.touch_count == 2'd0 || rise))
                    begin
                        st_next.levels      = st_next.levels & ~btn_mask(st_next.held_button);
                        st_next.held_active = 1'b0;
                    end
                    if (f.touch_count == 2'd0)
                    begin
                        st_next.moving = 1'b0;
                    end
                    if (st_reg.prev_count == 2'd0 || !rise)
                    begin
                        st_next.anchor_x = f.touch_x;
                        st_next.anchor_y = f.touch_y;
                        st_next.rem_x    = 7'd0;
                        st_next.rem_y    = 7'd0;
                    end
                    st_next.prev_count = f.touch_count;
                end
                dx_raw = {f.touch_x[15], f.touch_x} - {st_next.anchor_x[15], st_next.anchor_x};
                dy_raw = {f.touch_y[15], f.touch_y} - {st_next.anchor_y[15], st_next.anchor_y};
                dx_acc = {dx_raw[16], dx_raw} + {{11{st_next.rem_x[6]}}, st_next.rem_x};
                dy_acc = {dy_raw[16], dy_raw} + {{11{st_next.rem_y[6]}}, st_next.rem_y};
                dq_x   = div64(dx_acc);
                dq_y   = div64(dy_acc);
                if (f.touch_count == 2'd1 && (dx_raw != 17'd0 || dy_raw != 17'd0) &&
                    (st_next.moving || far_move(dx_raw) || far_move(dy_raw)))
                begin
                    st_next.anchor_x = f.touch_x;
                    st_next.anchor_y = f.touch_y;
                    st_next.rem_x    = dq_x.r;
                    st_next.rem_y    = dq_y.r;
                    st_next.moving   = 1'b1;
                    rel_x = {{4{dq_x.q[11]}}, dq_x.q};
                    rel_y = {{4{dq_y.q[11]}}, dq_y.q};
                    px    = px + {{6{dq_x.q[11]}}, dq_x.q};
                    py    = py + {{6{dq_y.q[11]}}, dq_y.q};
                end
                // long still press gives a held button, a tap click times out
                if (!st_next.held_active && f.touch_count != 2'd0 && !st_next.moving &&
                    st_next.press_armed &&
                    (f.time_us - st_next.press_time) >= tpgm_pkg::HOLD_US)
                begin
                    st_next.held_active = 1'b1;
                    st_next.hold_time   = f.time_us;
                    st_next.tap_click   = 1'b0;
                    st_next.held_button = f.touch_count - 2'd1;
                    st_next.levels      = st_next.levels | btn_mask(f.touch_count - 2'd1);
                end
                else if (st_next.held_active && st_next.tap_click &&
                         (f.time_us - st_next.hold_time) >= tpgm_pkg::TAP_US)
                begin
                    st_next.levels      = st_next.levels & ~btn_mask(st_next.held_button);
                    st_next.held_active = 1'b0;
                end
            end
            tpgm_pkg::MODE_ABS:
            begin
                rel_x          = f.mouse_dx;
                rel_y          = f.mouse_dy;
                px             = {6'd0, prep.abs_x};
                py             = {6'd0, prep.abs_y};
                st_next.levels = f.mouse_buttons;
            end
            tpgm_pkg::MODE_REL:
            begin
                rel_x          = f.mouse_dx;
                rel_y          = f.mouse_dy;
                px             = px + {{2{f.mouse_dx[15]}}, f.mouse_dx};
                py             = py + {{2{f.mouse_dy[15]}}, f.mouse_dy};
                st_next.levels = f.mouse_buttons;
            end
            default:
            begin
                rel_x          = f.mouse_dx;
                rel_y          = f.mouse_dy;
                st_next.levels = f.mouse_buttons;
            end
        endcase
        cx_next = clamp_pos(px, hi_x);
        cy_next = clamp_pos(py, hi_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            cx_reg        <= tpgm_pkg::CURSOR_RESET_X;
            cy_reg        <= tpgm_pkg::CURSOR_RESET_Y;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                st_reg <= st_next;
                cx_reg <= cx_next;
                cy_reg <= cy_next;
            end
            if (prep_ready)
            begin
                out_valid_reg <= prep_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dx_out_reg <= rel_x;
            dy_out_reg <= rel_y;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_x      = cx_reg;
    assign cursor_y      = cy_reg;
    assign delta_x       = dx_out_reg;
    assign delta_y       = dy_out_reg;
    assign button_levels = st_reg.levels;

`ifndef ASSERT_OFF
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.rem_x != 7'h40 && st_reg.rem_y != 7'h40)
        else $error("drag remainder reached -64");

    a_moving_needs_finger: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.moving |-> st_reg.prev_count != 2'd0)
        else $error("drag active with no finger down");

    a_cursor_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cx_reg <= tpgm_pkg::CURSOR_X_MAX)
        else $error("cursor x beyond widest screen");

    a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("request taken without a result");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the touch and pointer gesture mapper.
module testbench;

    typedef struct packed {
        logic [10:0] cursor_x;
        logic [10:0] cursor_y;
        logic [15:0] delta_x;
        logic [15:0] delta_y;
        logic [2:0]  buttons;
    } report_t;

    typedef struct {
        tpgm_pkg::mode_t  mode;
        tpgm_pkg::frame_t frame;
        logic             known;
        report_t          report;
    } script_row_t;

    localparam int      DRAG_STEP  = 64;
    localparam int      SCRIPT_LEN = 25;
    localparam int      PHASES     = 12;
    localparam int      PHASE_LEN  = 75;
    localparam report_t NO_REPORT  = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = tpgm_pkg::REG_MODE;
    logic [11:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  touch_count = '0;
    logic [15:0] touch_x = '0;
    logic [15:0] touch_y = '0;
    logic [15:0] mouse_dx = '0;
    logic [15:0] mouse_dy = '0;
    logic [2:0]  mouse_buttons = '0;
    logic [31:0] time_us = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [10:0] cursor_x;
    logic [10:0] cursor_y;
    logic [15:0] delta_x;
    logic [15:0] delta_y;
    logic [2:0]  button_levels;

    touch_pointer_gesture_mapper u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .touch_count   (touch_count),
        .touch_x       (touch_x),
        .touch_y       (touch_y),
        .mouse_dx      (mouse_dx),
        .mouse_dy      (mouse_dy),
        .mouse_buttons (mouse_buttons),
        .time_us       (time_us),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cursor_x      (cursor_x),
        .cursor_y      (cursor_y),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .button_levels (button_levels)
    );

    always #5 clk = ~clk;

    // Mirror of the register file and the gesture state
    tpgm_pkg::mode_t    cfg_mode = tpgm_pkg::MODE_ABS;
    logic [11:0]        cfg_width = tpgm_pkg::RESET_WIDTH;
    logic [11:0]        cfg_height = tpgm_pkg::RESET_HEIGHT;
    logic [1:0]         last_count = '0;
    logic [1:0]         held_btn = '0;
    logic               held_on = 1'b0;
    logic               dragging = 1'b0;
    logic               tap_press = 1'b0;
    logic               armed = 1'b0;
    logic signed [15:0] anchor_x = '0;
    logic signed [15:0] anchor_y = '0;
    logic signed [6:0]  rem_x = '0;
    logic signed [6:0]  rem_y = '0;
    logic [31:0]        press_at = '0;
    logic [31:0]        held_at = '0;
    logic [11:0]        pos_x = 12'd250;
    logic [11:0]        pos_y = 12'd165;
    logic [2:0]         levels = '0;

    report_t     pending_reports[$];
    int          mismatches = 0;
    int          frames_sent = 0;
    int          stall_left = 0;
    logic        steady = 1'b0;
    logic [31:0] now_us = '0;

    script_row_t script [0:SCRIPT_LEN-1] = '{
        // absolute mode, reset screen 640x480
        '{tpgm_pkg::MODE_ABS,
          '{2'd0, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 3'd7, 32'd0},
          1'b1, '{11'd0, 11'd0, 16'h7fff, 16'h8000, 3'd7}},
        '{tpgm_pkg::MODE_ABS,
          '{2'd0, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 3'd0, 32'd10},
          1'b1, '{11'd630, 11'd479, 16'h8000, 16'h7fff, 3'd0}},
        '{tpgm_pkg::MODE_ABS,
          '{2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd5, 32'd20},
          1'b1, '{11'd320, 11'd240, 16'h0000, 16'h0000, 3'd5}},
        '{tpgm_pkg::MODE_ABS,
          '{2'd1, 16'h8001, 16'h7ffe, 16'h0001, 16'hffff, 3'd2, 32'd30},
          1'b0, NO_REPORT},
        // relative mode, clamped at both corners
        '{tpgm_pkg::MODE_REL,
          '{2'd0, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 3'd1, 32'd40},
          1'b1, '{11'd630, 11'd479, 16'h7fff, 16'h7fff, 3'd1}},
        '{tpgm_pkg::MODE_REL,
          '{2'd2, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 3'd6, 32'd50},
          1'b1, '{11'd0, 11'd0, 16'h8000, 16'h8000, 3'd6}},
        '{tpgm_pkg::MODE_REL,
          '{2'd0, 16'h0000, 16'h0000, 16'h0005, 16'h0003, 3'd2, 32'd60},
          1'b1, '{11'd5, 11'd3, 16'h0005, 16'h0003, 3'd2}},
        '{tpgm_pkg::MODE_FROZEN,
          '{2'd0, 16'h1234, 16'h4321, 16'h0064, 16'hffff, 3'd4, 32'd70},
          1'b0, NO_REPORT},
        // touchpad: tap, hold, drag, multi-finger tap, hold across the time wrap
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd1, 16'h0000, 16'h0000, 16'h1111, 16'h2222, 3'd3, 32'd1000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd1, 16'h0064, 16'h0000, 16'h0000, 16'h0000, 3'd0, 32'd2000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd0, 16'h0064, 16'h0000, 16'h0000, 16'h0000, 3'd0, 32'd3000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd0, 32'd103000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd2, 16'h0100, 16'h0200, 16'h0000, 16'h0000, 3'd7, 32'd200000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd2, 16'h0100, 16'h0200, 16'h0000, 16'h0000, 3'd7, 32'd700000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd0, 16'h0100, 16'h0200, 16'h0000, 16'h0000, 3'd0, 32'd710000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd0, 32'd800000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd1, 16'h03e8, 16'hfed4, 16'h0000, 16'h0000, 3'd0, 32'd810000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd1, 16'h044c, 16'hfeca, 16'h0000, 16'h0000, 3'd0, 32'd820000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd0, 16'h044c, 16'hfeca, 16'h0000, 16'h0000, 3'd0, 32'd830000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd3, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 3'd0, 32'd900000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd1, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 3'd0, 32'd910000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd0, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 3'd0, 32'd1100000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd1, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 3'd0, 32'hffff0000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd1, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 3'd0, 32'h00080000},
          1'b0, NO_REPORT},
        '{tpgm_pkg::MODE_TOUCH,
          '{2'd0, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 3'd0, 32'h00090000},
          1'b0, NO_REPORT}
    };

    function automatic int screen_size(logic [11:0] v);
        if (v < tpgm_pkg::SIZE_MIN)
            return int'(tpgm_pkg::SIZE_MIN);
        if (v > tpgm_pkg::SIZE_MAX)
            return int'(tpgm_pkg::SIZE_MAX);
        return int'(v);
    endfunction

    function automatic int scale_touch(int t, int size);
        int a;
        a = (t < -32767) ? 0 : t + int'(tpgm_pkg::SCALE_OFS);
        return int'((longint'(a) * size + size / 2 - 1) / longint'(tpgm_pkg::SCALE_DIV));
    endfunction

    function automatic int limit(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [2:0] button_mask(logic [1:0] b);
        logic [3:0] m;
        m = 4'b0001 << b;
        return m[2:0];
    endfunction

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Cursor, motion and button levels for one frame; advances the mirrored state
    function automatic report_t advance_pointer(tpgm_pkg::frame_t f);
        int          w, h, px, py, relx, rely, tx, ty, dx, dy;
        logic        rise;
        logic [31:0] elapsed;
        report_t     r;
        w = screen_size(cfg_width);
        h = screen_size(cfg_height);
        px = int'(pos_x);
        py = int'(pos_y);
        relx = 0;
        rely = 0;
        tx = int'($signed(f.touch_x));
        ty = int'($signed(f.touch_y));
        if (cfg_mode == tpgm_pkg::MODE_TOUCH)
        begin
            if (last_count != f.touch_count)
            begin
                rise = f.touch_count > last_count;
                if (rise)
                begin
                    press_at = f.time_us;
                    armed = 1'b1;
                end
                // finger lifted soon enough: tap on the button named by the fingers left
                if (!held_on && !rise && armed && (!dragging || f.touch_count != 0))
                begin
                    held_on = 1'b1;
                    held_at = f.time_us;
                    tap_press = 1'b1;
                    held_btn = f.touch_count;
                    levels = levels | button_mask(held_btn);
                    armed = 1'b0;
                end
                else if (held_on && (f.touch_count == 0 || rise))
                begin
                    levels = levels & ~button_mask(held_btn);
                    held_on = 1'b0;
                end
                if (f.touch_count == 0)
                    dragging = 1'b0;
                if (last_count == 0 || !rise)
                begin
                    anchor_x = 16'(tx);
                    anchor_y = 16'(ty);
                    rem_x = '0;
                    rem_y = '0;
                end
                last_count = f.touch_count;
            end
            if (f.touch_count == 1 && (tx != anchor_x || ty != anchor_y))
            begin
                dx = tx - anchor_x;
                dy = ty - anchor_y;
                if (dragging || magnitude(dx) >= int'(tpgm_pkg::DRAG_START) ||
                    magnitude(dy) >= int'(tpgm_pkg::DRAG_START))
                begin
                    anchor_x = 16'(tx);
                    dx = dx + rem_x;
                    rem_x = 7'(dx % DRAG_STEP);
                    relx = dx / DRAG_STEP;
                    px = px + relx;
                    anchor_y = 16'(ty);
                    dy = dy + rem_y;
                    rem_y = 7'(dy % DRAG_STEP);
                    rely = dy / DRAG_STEP;
                    py = py + rely;
                    dragging = 1'b1;
                end
            end
            elapsed = f.time_us - press_at;
            if (!held_on && f.touch_count != 0 && !dragging && armed &&
                elapsed >= tpgm_pkg::HOLD_US)
            begin
                held_on = 1'b1;
                held_at = f.time_us;
                tap_press = 1'b0;
                held_btn = f.touch_count - 2'd1;
                levels = levels | button_mask(held_btn);
            end
            else if (held_on && tap_press && (f.time_us - held_at) >= tpgm_pkg::TAP_US)
            begin
                levels = levels & ~button_mask(held_btn);
                held_on = 1'b0;
            end
        end
        else
        begin
            relx = int'($signed(f.mouse_dx));
            rely = int'($signed(f.mouse_dy));
            if (cfg_mode == tpgm_pkg::MODE_ABS)
            begin
                px = scale_touch(tx, w);
                py = scale_touch(ty, h);
            end
            else if (cfg_mode == tpgm_pkg::MODE_REL)
            begin
                px = px + relx;
                py = py + rely;
            end
            levels = f.mouse_buttons;
        end
        pos_x = 12'(limit(px, w - 10));
        pos_y = 12'(limit(py, h - 1));
        r.cursor_x = pos_x[10:0];
        r.cursor_y = pos_y[10:0];
        r.delta_x = 16'(relx);
        r.delta_y = 16'(rely);
        r.buttons = levels;
        return r;
    endfunction

    // Mostly back to back, now and then a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%h, actual 0x%h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (steady || $urandom_range(0, 3) != 0)
            out_ready <= 1'b1;
        else
        begin
            stall_left <= pick_gap();
            out_ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("cursor_x", 16'(want.cursor_x), 16'(cursor_x));
                check_field("cursor_y", 16'(want.cursor_y), 16'(cursor_y));
                check_field("delta_x", want.delta_x, delta_x);
                check_field("delta_y", want.delta_y, delta_y);
                check_field("button_levels", 16'(want.buttons), 16'(button_levels));
            end
        end
    end

    task automatic apply_frame(input tpgm_pkg::frame_t f, input logic known,
                               input report_t fixed);
        int      gap;
        report_t predicted;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        touch_count <= f.touch_count;
        touch_x <= f.touch_x;
        touch_y <= f.touch_y;
        mouse_dx <= f.mouse_dx;
        mouse_dy <= f.mouse_dy;
        mouse_buttons <= f.mouse_buttons;
        time_us <= f.time_us;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = advance_pointer(f);
        pending_reports.push_back(known ? fixed : predicted);
        frames_sent++;
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        drain_reports();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            tpgm_pkg::REG_MODE:   cfg_mode = tpgm_pkg::mode_t'(value[1:0]);
            tpgm_pkg::REG_WIDTH:  cfg_width = value;
            tpgm_pkg::REG_HEIGHT: cfg_height = value;
            default:              ;
        endcase
    endtask

    function automatic logic [11:0] pick_size();
        case ($urandom_range(0, 5))
            0:       return tpgm_pkg::SIZE_MIN;
            1:       return tpgm_pkg::SIZE_MAX;
            2:       return 12'($urandom_range(0, 255));
            3:       return 12'($urandom_range(2049, 4095));
            default: return 12'($urandom_range(256, 2048));
        endcase
    endfunction

    function automatic int sat16(int v);
        return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
    endfunction

    function automatic int wide_pos();
        case ($urandom_range(0, 19))
            0:       return -32768;
            1:       return 32767;
            2:       return -32767;
            3:       return 0;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int drag_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return int'($urandom_range(0, 600)) - 300;
        if (r < 90)
            return int'($urandom_range(0, 4000)) - 2000;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic tpgm_pkg::frame_t touch_frame(logic [1:0] count, int x, int y,
                                                     int lo, int hi);
        tpgm_pkg::frame_t f;
        now_us = now_us + 32'($urandom_range(lo, hi));
        f.touch_count = count;
        f.touch_x = 16'(x);
        f.touch_y = 16'(y);
        f.mouse_dx = 16'($urandom);
        f.mouse_dy = 16'($urandom);
        f.mouse_buttons = 3'($urandom);
        f.time_us = now_us;
        return f;
    endfunction

    function automatic tpgm_pkg::frame_t mouse_frame();
        tpgm_pkg::frame_t f;
        f = touch_frame(2'($urandom), wide_pos(), wide_pos(), 1, 40000);
        if ($urandom_range(0, 3) != 0)
        begin
            f.mouse_dx = 16'($urandom_range(0, 400) - 200);
            f.mouse_dy = 16'($urandom_range(0, 400) - 200);
        end
        return f;
    endfunction

    // One touch gesture of one to three fingers with random content; a few are plain noise
    task automatic touch_gesture();
        int               kind, n, x, y, steps, lo, hi;
        logic [1:0]       lift;
        tpgm_pkg::frame_t f;
        kind = $urandom_range(0, 9);
        n = $urandom_range(1, 3);
        x = wide_pos();
        y = wide_pos();
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 3))
            begin
                f = touch_frame(2'($urandom), wide_pos(), wide_pos(), 0, 0);
                f.time_us = $urandom;
                now_us = f.time_us;
                apply_frame(f, 1'b0, NO_REPORT);
            end
        end
        else if (kind == 8)
        begin
            repeat ($urandom_range(3, 8))
            begin
                x = sat16(x + int'($urandom_range(0, 40)) - 20);
                apply_frame(touch_frame(2'($urandom), x, y, 0, 600000), 1'b0, NO_REPORT);
            end
        end
        else
        begin
            if (kind >= 5)
                n = 1;
            apply_frame(touch_frame(2'(n), x, y, 1000, 300000), 1'b0, NO_REPORT);
            if (kind < 3)
            begin
                steps = $urandom_range(0, 2);
                lo = 1000;
                hi = 30000;
            end
            else if (kind < 5)
            begin
                steps = $urandom_range(3, 6);
                lo = 50000;
                hi = 200000;
            end
            else
            begin
                steps = $urandom_range(3, 12);
                lo = 5000;
                hi = 20000;
            end
            repeat (steps)
            begin
                if (kind >= 5)
                begin
                    x = sat16(x + drag_step());
                    y = sat16(y + drag_step());
                end
                else
                begin
                    x = sat16(x + int'($urandom_range(0, 40)) - 20);
                    y = sat16(y + int'($urandom_range(0, 40)) - 20);
                end
                apply_frame(touch_frame(2'(n), x, y, lo, hi), 1'b0, NO_REPORT);
            end
            // second finger mid-drag keeps the anchor
            if (kind == 7)
            begin
                n = 2;
                apply_frame(touch_frame(2'(n), sat16(x + drag_step()), y, 1000, 20000),
                            1'b0, NO_REPORT);
            end
            lift = 2'($urandom_range(0, n - 1));
            repeat ($urandom_range(1, 3))
                apply_frame(touch_frame(lift, x, y, 20000, 80000), 1'b0, NO_REPORT);
            if (lift != 0)
                apply_frame(touch_frame(2'd0, x, y, 1000, 150000), 1'b0, NO_REPORT);
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int   i, phase, start, pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < SCRIPT_LEN; i++)
        begin
            if (script[i].mode != cfg_mode)
                write_reg(tpgm_pkg::REG_MODE, 12'(script[i].mode));
            apply_frame(script[i].frame, script[i].known, script[i].report);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            // every mode once, then touchpad in about half of the phases, the other modes less often
            if (phase < 4)
                pick = phase;
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    pick = int'(tpgm_pkg::MODE_TOUCH);
                else if (pick < 7)
                    pick = int'(tpgm_pkg::MODE_REL);
                else if (pick < 9)
                    pick = int'(tpgm_pkg::MODE_ABS);
                else
                    pick = int'(tpgm_pkg::MODE_FROZEN);
            end
            write_reg(tpgm_pkg::REG_MODE, {10'($urandom), 2'(pick)});
            write_reg(tpgm_pkg::REG_WIDTH, pick_size());
            write_reg(tpgm_pkg::REG_HEIGHT, pick_size());
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0)
                now_us = 32'hffff_ffff - 32'($urandom_range(0, 2000000));
            start = frames_sent;
            while (frames_sent - start < PHASE_LEN)
            begin
                if (cfg_mode == tpgm_pkg::MODE_TOUCH)
                    touch_gesture();
                else
                    apply_frame(mouse_frame(), 1'b0, NO_REPORT);
            end
        end
        steady = 1'b0;

        drain_reports();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
src/tpgm_pkg.sv
src/tpgm_front.sv
src/tpgm_core.sv
src/touch_pointer_gesture_mapper.sv
test/testbench.sv
